// ===== rtl/core/spjq_pkg.sv =====
// Shared types and constants for the strict priority job queue.
package spjq_pkg;

    // Queue geometry
    localparam int LEVELS   = 3;
    localparam int DEPTH    = 16;
    localparam int LVL_W    = $clog2(LEVELS);
    localparam int PTR_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int ADDR_W   = LVL_W + PTR_W;
    localparam int MEM_SIZE = LEVELS << PTR_W;

    // Request operation
    typedef enum logic {
        KIND_ENQ = 1'b0,
        KIND_DEQ = 1'b1
    } kind_t;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_ENQUEUED = 2'd0,
        STAT_DEQUEUED = 2'd1,
        STAT_EMPTY    = 2'd2,
        STAT_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        kind_t       kind;
        logic [1:0]  level;
        logic [31:0] job_id;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] out_job;
        logic [1:0]  out_level;
    } rsp_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
    } dp_stat_t;

endpackage

// ===== rtl/core/strict_priority_job_queue.sv =====
// Top level of the strict priority job queue: controller plus datapath.
//
//  channel   direction  handshake          payload
//  s_        in         s_valid / s_ready  req_t: kind, level, job_id
//  m_        out        m_valid / m_ready  rsp_t: status, out_job, out_level
//
// Each request passes through capture, execute (pointer update and
// store access), then load into the result register.
// The job store read is registered, which sets the execute-to-load step.
// A new request is taken while the previous result still waits in m_data.
// A stalled m_ready holds the next result in the load step and s_ready low.
// Reset (aresetn low, synchronous) empties every level; no clearing pass.
module strict_priority_job_queue
    import spjq_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_data
);

    cmd_t     cmd;
    dp_stat_t stat;

    spjq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    spjq_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_data  (m_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

endmodule

// ===== rtl/core/spjq_ctrl.sv =====
// Sequencing state machine for the strict priority job queue.
module spjq_ctrl
    import spjq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dp_stat_t stat,
    output cmd_t     cmd
);

    state_t state_reg;
    state_t state_next;

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Advance through capture, execute and result load; take nothing in reset
    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        s_ready     = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = aresetn;
                if (s_valid && aresetn) begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD: begin
                if (stat.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/spjq_dp.sv =====
// Datapath: job store, per-level pointers and counts, result register.
module spjq_dp
    import spjq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  req_t     s_data,
    output rsp_t     m_data,
    output logic     m_valid,
    input  logic     m_ready,
    input  cmd_t     cmd,
    output dp_stat_t stat
);

    logic [31:0]      mem [MEM_SIZE];
    logic [31:0]      rdata_reg;
    req_t             req_reg;
    logic [PTR_W-1:0] head_reg [LEVELS];
    logic [PTR_W-1:0] tail_reg [LEVELS];
    logic [CNT_W-1:0] count_reg [LEVELS];
    status_t          res_status_reg;
    logic [LVL_W-1:0] res_level_reg;
    rsp_t             m_data_reg;
    logic             m_valid_reg;

    logic             enq_ok;
    logic [LVL_W-1:0] enq_lvl;
    logic             deq_hit;
    logic [LVL_W-1:0] deq_lvl;
    logic             do_write;
    logic             do_read;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic             cnt_ok;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Capture the accepted request
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg <= s_data;
        end
    end

    // Decide the operation: level check and highest non-empty level
    always_comb begin
        enq_lvl = LVL_W'(req_reg.level);
        enq_ok  = (int'(req_reg.level) < LEVELS) &&
                  (count_reg[enq_lvl] < CNT_W'(DEPTH));
        deq_hit = 1'b0;
        deq_lvl = '0;
        for (int i = 0; i < LEVELS; i++) begin
            if (count_reg[i] != '0) begin
                deq_hit = 1'b1;
                deq_lvl = LVL_W'(i);
            end
        end
        do_write = cmd.exec && (req_reg.kind == KIND_ENQ) && enq_ok;
        do_read  = cmd.exec && (req_reg.kind == KIND_DEQ) && deq_hit;
        wr_addr  = {enq_lvl, tail_reg[enq_lvl]};
        rd_addr  = {deq_lvl, head_reg[deq_lvl]};
    end

    // Job store: one write port, registered read
    always_ff @(posedge aclk) begin
        if (do_write) begin
            mem[wr_addr] <= req_reg.job_id;
        end
        if (do_read) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Advance pointers and counts
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LEVELS; i++) begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end else begin
            if (do_write) begin
                tail_reg[enq_lvl]  <= next_slot(tail_reg[enq_lvl]);
                count_reg[enq_lvl] <= count_reg[enq_lvl] + 1'b1;
            end
            if (do_read) begin
                head_reg[deq_lvl]  <= next_slot(head_reg[deq_lvl]);
                count_reg[deq_lvl] <= count_reg[deq_lvl] - 1'b1;
            end
        end
    end

    // Record outcome of the operation
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            res_level_reg <= deq_lvl;
            if (req_reg.kind == KIND_ENQ) begin
                res_status_reg <= enq_ok ? STAT_ENQUEUED : STAT_FULL;
            end else begin
                res_status_reg <= deq_hit ? STAT_DEQUEUED : STAT_EMPTY;
            end
        end
    end

    // Output register: load result, drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            m_data_reg.status <= res_status_reg;
            if (res_status_reg == STAT_DEQUEUED) begin
                m_data_reg.out_job   <= rdata_reg;
                m_data_reg.out_level <= 2'(res_level_reg);
            end else begin
                m_data_reg.out_job   <= '0;
                m_data_reg.out_level <= '0;
            end
        end
    end

    assign m_data        = m_data_reg;
    assign m_valid       = m_valid_reg;
    assign stat.out_free = !m_valid_reg || m_ready;

    always_comb begin
        cnt_ok = 1'b1;
        for (int i = 0; i < LEVELS; i++) begin
            if (count_reg[i] > CNT_W'(DEPTH)) begin
                cnt_ok = 1'b0;
            end
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_ok)
        else $error("level count exceeds depth");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> (!m_valid_reg || m_ready))
        else $error("result loaded over a pending result");

    a_deq_level: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.status == STAT_DEQUEUED)
            |-> (int'(m_data_reg.out_level) < LEVELS))
        else $error("dequeued level out of range");

    a_zero_job: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.status != STAT_DEQUEUED)
            |-> (m_data_reg.out_job == '0 && m_data_reg.out_level == '0))
        else $error("non-dequeue result carries a job");

    a_no_dual: assert property (@(posedge aclk) disable iff (!aresetn)
        !(do_write && do_read))
        else $error("store written and read for one request");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Testbench for the strict priority job queue: directed table, random bursts, scoreboard.
module tb
    import spjq_pkg::*;
();

    localparam int RAND_REQS  = 900;
    localparam int CALM_TAIL  = 150;
    localparam int IDLE_LIMIT = 2000;
    localparam int NUM_DIR    = 18;

    // One row of the directed table; want is used only when typed is set
    typedef struct packed {
        req_t    req;
        logic    typed;
        rsp_t    want;
    } dir_row_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rsp_t m_data;

    // Side band that travels with each request: a hand-typed expectation
    logic req_typed = 1'b0;
    rsp_t req_want  = '0;

    // Predicted queue contents
    logic [31:0] held_jobs [LEVELS][DEPTH];
    int unsigned rd_slot   [LEVELS];
    int unsigned wr_slot   [LEVELS];
    int unsigned held_cnt  [LEVELS];

    rsp_t owed_rsp [$];
    int   fails       = 0;
    int   reqs_sent   = 0;
    int   idle_cycles = 0;
    int   n_enq = 0, n_deq = 0, n_empty = 0, n_full = 0;
    bit   idle_on = 1'b0;

    dir_row_t dir_rows [NUM_DIR];

    strict_priority_job_queue dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Apply one request to the predicted queues and return the answer it earns
    function automatic rsp_t run_job_op(req_t r);
        rsp_t rsp;
        bit   found;
        int   lv;
        rsp   = '0;
        found = 1'b0;
        if (r.kind == KIND_ENQ) begin
            if (r.level >= LEVELS || held_cnt[r.level] >= DEPTH) begin
                rsp.status = STAT_FULL;
            end else begin
                held_jobs[r.level][wr_slot[r.level]] = r.job_id;
                wr_slot[r.level] = (wr_slot[r.level] == DEPTH - 1) ? 0 : wr_slot[r.level] + 1;
                held_cnt[r.level]++;
                rsp.status = STAT_ENQUEUED;
            end
        end else begin
            // highest non-empty level wins
            for (lv = LEVELS - 1; lv >= 0; lv--) begin
                if (!found && held_cnt[lv] != 0) begin
                    found         = 1'b1;
                    rsp.status    = STAT_DEQUEUED;
                    rsp.out_job   = held_jobs[lv][rd_slot[lv]];
                    rsp.out_level = 2'(lv);
                    rd_slot[lv]   = (rd_slot[lv] == DEPTH - 1) ? 0 : rd_slot[lv] + 1;
                    held_cnt[lv]--;
                end
            end
            if (!found) rsp.status = STAT_EMPTY;
        end
        return rsp;
    endfunction

    function automatic dir_row_t dir_row(kind_t k, logic [1:0] lv, logic [31:0] job,
                                         logic typed, status_t st);
        dir_row_t row;
        row              = '0;
        row.req.kind     = k;
        row.req.level    = lv;
        row.req.job_id   = job;
        row.typed        = typed;
        row.want.status  = st;
        return row;
    endfunction

    // Predict on accepted requests, check accepted results
    always @(posedge aclk) begin : scoreboard
        rsp_t want;
        logic moved;
        moved = 1'b0;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                want = run_job_op(s_data);
                if (req_typed) want = req_want;
                owed_rsp.push_back(want);
                moved = 1'b1;
            end
            if (m_valid && m_ready) begin
                moved = 1'b1;
                if (owed_rsp.size() == 0) begin
                    $error("unexpected result: status %0d out_job %h out_level %0d",
                           m_data.status, m_data.out_job, m_data.out_level);
                    fails++;
                end else begin
                    want = owed_rsp.pop_front();
                    if (m_data.status !== want.status) begin
                        $error("status mismatch: expected %0d, got %0d",
                               want.status, m_data.status);
                        fails++;
                    end
                    if (m_data.out_job !== want.out_job) begin
                        $error("out_job mismatch: expected %h, got %h",
                               want.out_job, m_data.out_job);
                        fails++;
                    end
                    if (m_data.out_level !== want.out_level) begin
                        $error("out_level mismatch: expected %0d, got %0d",
                               want.out_level, m_data.out_level);
                        fails++;
                    end
                    case (m_data.status)
                        STAT_ENQUEUED: n_enq++;
                        STAT_DEQUEUED: n_deq++;
                        STAT_EMPTY:    n_empty++;
                        default:       n_full++;
                    endcase
                end
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
    end

    // Receiver: stall in short random bursts while idling is enabled
    initial begin : sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (stall_left > 0) begin
                stall_left--;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 3);
            end
            m_ready <= (stall_left == 0) && aresetn;
        end
    end

    // Stop the run when nothing moves for too long
    initial begin : watchdog
        while (idle_cycles < IDLE_LIMIT) @(posedge aclk);
        $display("tb failed");
        $finish;
    end

    // Present one request, with an optional random gap ahead of it
    task automatic send_req(req_t r, logic typed, rsp_t want);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_data    <= r;
        req_typed <= typed;
        req_want  <= want;
        do @(posedge aclk); while (!s_ready);
        reqs_sent++;
    endtask

    // Drop valid and hold until every owed result has come back
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (owed_rsp.size() != 0) @(posedge aclk);
    endtask

    task automatic send_random(kind_t k, logic [1:0] lv);
        req_t r;
        r.kind   = k;
        r.level  = lv;
        r.job_id = $urandom;
        send_req(r, 1'b0, '0);
    endtask

    initial begin : stim
        int   i;
        int   mode;
        int   burst;
        int   lv;
        bit   paused;
        paused = 1'b0;
        for (i = 0; i < LEVELS; i++) begin
            rd_slot[i]  = 0;
            wr_slot[i]  = 0;
            held_cnt[i] = 0;
        end

        // extremes, out-of-range level, empty queue, priority order
        dir_rows = '{
            dir_row(KIND_DEQ, 2'd0, 32'h0000_0000, 1'b1, STAT_EMPTY),
            dir_row(KIND_DEQ, 2'd3, 32'hFFFF_FFFF, 1'b1, STAT_EMPTY),
            dir_row(KIND_ENQ, 2'd0, 32'h0000_0000, 1'b1, STAT_ENQUEUED),
            dir_row(KIND_ENQ, 2'd0, 32'hFFFF_FFFF, 1'b1, STAT_ENQUEUED),
            dir_row(KIND_ENQ, 2'd1, 32'h1234_5678, 1'b1, STAT_ENQUEUED),
            dir_row(KIND_ENQ, 2'd2, 32'h8000_0000, 1'b1, STAT_ENQUEUED),
            dir_row(KIND_ENQ, 2'd3, 32'hDEAD_BEEF, 1'b1, STAT_FULL),
            dir_row(KIND_ENQ, 2'd2, 32'h0000_0001, 1'b1, STAT_ENQUEUED),
            dir_row(KIND_DEQ, 2'd0, 32'h0000_0000, 1'b0, STAT_EMPTY),
            dir_row(KIND_ENQ, 2'd1, 32'hA5A5_A5A5, 1'b1, STAT_ENQUEUED),
            dir_row(KIND_DEQ, 2'd1, 32'h5A5A_5A5A, 1'b0, STAT_EMPTY),
            dir_row(KIND_DEQ, 2'd0, 32'h0000_0000, 1'b0, STAT_EMPTY),
            dir_row(KIND_DEQ, 2'd0, 32'h0000_0000, 1'b0, STAT_EMPTY),
            dir_row(KIND_DEQ, 2'd0, 32'h0000_0000, 1'b0, STAT_EMPTY),
            dir_row(KIND_DEQ, 2'd2, 32'h7FFF_FFFF, 1'b0, STAT_EMPTY),
            dir_row(KIND_DEQ, 2'd0, 32'h0000_0000, 1'b1, STAT_EMPTY),
            dir_row(KIND_ENQ, 2'd3, 32'h0000_0000, 1'b1, STAT_FULL),
            dir_row(KIND_DEQ, 2'd3, 32'h0000_0000, 1'b1, STAT_EMPTY)
        };

        // hold reset, then release it
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < NUM_DIR; i++) begin
            send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
        end
        hold_until_drained();

        // random bursts: fill a level past full, drain toward empty, or mixed traffic
        idle_on = 1'b1;
        reqs_sent = 0;
        while (reqs_sent < RAND_REQS) begin
            if (reqs_sent >= RAND_REQS - CALM_TAIL) idle_on = 1'b0;
            if (!paused && reqs_sent >= RAND_REQS / 2) begin
                hold_until_drained();
                paused = 1'b1;
            end
            mode = $urandom_range(0, 9);
            if (mode < 2) begin
                lv = $urandom_range(0, LEVELS - 1);
                repeat (DEPTH + 1) send_random(KIND_ENQ, 2'(lv));
            end else if (mode < 4) begin
                burst = $urandom_range(4, LEVELS * DEPTH + 2);
                repeat (burst) send_random(KIND_DEQ, 2'($urandom_range(0, 3)));
            end else begin
                burst = $urandom_range(1, 20);
                repeat (burst) begin
                    if ($urandom_range(0, 15) == 0) lv = 3;
                    else lv = $urandom_range(0, LEVELS - 1);
                    send_random($urandom_range(0, 1) ? KIND_DEQ : KIND_ENQ, 2'(lv));
                end
            end
        end

        // drain, then give stray results time to show up
        idle_on = 1'b0;
        hold_until_drained();
        repeat (8) @(posedge aclk);
        if (owed_rsp.size() != 0) begin
            $error("%0d results never arrived", owed_rsp.size());
            fails++;
        end

        $display("covered %0d enqueued, %0d dequeued, %0d empty, %0d rejected results",
                 n_enq, n_deq, n_empty, n_full);
        $display("with random stalls on both channels, level fill and drain bursts");
        if (fails == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
